// ----- rtl/core/uer_pkg.sv -----
package uer_pkg;

	// Default build values
	localparam int SENSOR_COUNT_DEF = 4;
	localparam int TIMER_BITS_DEF   = 24;

	// Register and field widths
	localparam int TEMP_W     = 8;
	localparam int TRIG_W     = 16;
	localparam int GAP_W      = 24;
	localparam int CNT_W      = 24;
	localparam int DIST_W     = 26;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_TEMP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP  = 2'd2;

	// Register reset values
	localparam logic [TEMP_W-1:0] TEMP_RST = 8'd20;
	localparam logic [TRIG_W-1:0] TRIG_RST = 16'd400;
	localparam logic [GAP_W-1:0]  GAP_RST  = 24'd2000000;

	// Speed of sound term: 3315 + 6 * temperature, always fits 12 bits
	localparam int SPEED_W       = 12;
	localparam int SPEED_BASE    = 3315;
	localparam int SPEED_PER_DEG = 6;

	// Divide by 1600 = shift by 6, then divide by 25 through a reciprocal.
	// Quotients at or above 2^26 saturate, so the reciprocal only sees
	// values below 25 * 2^26, which fit 31 bits.
	localparam int             DIV_SHIFT   = 6;
	localparam int             RECIP_IN_W  = 31;
	localparam int             RECIP_SHIFT = 36;
	localparam logic [31:0]    RECIP_MUL   = 32'd2748779070;
	localparam logic [63:0]    SAT_LIMIT   = 64'd25 << DIST_W;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// Live configuration as seen by the datapath
	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic [TRIG_W-1:0]  trig_lim;
		logic [GAP_W-1:0]   gap_lim;
	} uer_cfg_t;

endpackage

// ----- rtl/core/uer_if.sv -----
interface uer_tick_if #(
	parameter int SENSOR_COUNT = 4
);
	logic                    valid;
	logic                    ready;
	logic [SENSOR_COUNT-1:0] echo_levels;

	modport source (output valid, output echo_levels, input ready);
	modport sink   (input valid, input echo_levels, output ready);
endinterface

interface uer_result_if #(
	parameter int SENSOR_COUNT = 4
);
	localparam int IDX_W = $clog2(SENSOR_COUNT);

	logic                    valid;
	logic                    ready;
	logic [SENSOR_COUNT-1:0] trigger_drive;
	logic                    result_valid;
	logic [IDX_W-1:0]        sensor_index;
	logic [25:0]             distance_um;

	modport source (output valid, output trigger_drive, output result_valid,
		output sensor_index, output distance_um, input ready);
	modport sink   (input valid, input trigger_drive, input result_valid,
		input sensor_index, input distance_um, output ready);
endinterface

interface uer_cfg_if import uer_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/uer_cfg_regs.sv -----
module uer_cfg_regs import uer_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	uer_cfg_if.sink   cfg,
	output uer_cfg_t  cfg_live
);

	logic signed [TEMP_W-1:0] temp_q;
	logic [TRIG_W-1:0]        trig_q;
	logic [GAP_W-1:0]         gap_q;

	assign cfg.ready = 1'b1;

	// Capture register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= TEMP_RST;
			trig_q <= TRIG_RST;
			gap_q  <= GAP_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_TEMP: temp_q <= cfg.data[TEMP_W-1:0];
				REG_TRIG: trig_q <= cfg.data[TRIG_W-1:0];
				REG_GAP:  gap_q  <= cfg.data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	// Speed term and limits, zero length counts as one tick
	always_comb begin
		cfg_live.speed    = SPEED_W'(SPEED_BASE + SPEED_PER_DEG * int'(temp_q));
		cfg_live.trig_lim = (trig_q == '0) ? TRIG_W'(1) : trig_q;
		cfg_live.gap_lim  = (gap_q == '0) ? GAP_W'(1) : gap_q;
	end

endmodule

// ----- rtl/core/uer_seq.sv -----
module uer_seq import uer_pkg::*; #(
	parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
	parameter int TIMER_BITS   = TIMER_BITS_DEF,
	parameter int META_W       = SENSOR_COUNT + 1 + $clog2(SENSOR_COUNT)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	uer_tick_if.sink              tick,
	input  uer_cfg_t              cfg_live,
	output logic                  valid_s1,
	input  logic                  ready_s1,
	output logic [META_W-1:0]     meta_s1,
	output logic [TIMER_BITS-1:0] ticks_s1
);

	localparam int IDX_W = $clog2(SENSOR_COUNT);

	localparam logic [1:0] PH_TRIGGER   = 2'd0;
	localparam logic [1:0] PH_WAIT_RISE = 2'd1;
	localparam logic [1:0] PH_MEASURE   = 2'd2;
	localparam logic [1:0] PH_GAP       = 2'd3;

	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	logic [1:0]              phase_q, phase_d;
	logic [IDX_W-1:0]        sensor_q, sensor_d, sensor_next;
	logic [CNT_W-1:0]        count_q, count_d, count_inc;
	logic [SENSOR_COUNT-1:0] prev_q;
	logic [TIMER_BITS-1:0]   timer_q, timer_d, timer_inc;
	logic                    now_high, was_high, hit;
	logic [SENSOR_COUNT-1:0] drive;
	logic                    take;

	logic [SENSOR_COUNT-1:0] drive_s1;
	logic                    hit_s1;
	logic [IDX_W-1:0]        sensor_s1;

	assign tick.ready = !valid_s1 || ready_s1;
	assign take       = tick.valid && tick.ready;

	assign now_high    = tick.echo_levels[sensor_q];
	assign was_high    = prev_q[sensor_q];
	assign count_inc   = count_q + CNT_W'(1);
	assign timer_inc   = (timer_q == TIMER_MAX) ? timer_q : timer_q + TIMER_BITS'(1);
	assign sensor_next = (sensor_q == IDX_W'(SENSOR_COUNT - 1)) ? '0 : sensor_q + IDX_W'(1);

	// Next sensor state for this tick
	always_comb begin
		phase_d  = phase_q;
		sensor_d = sensor_q;
		count_d  = count_q;
		timer_d  = timer_q;
		hit      = 1'b0;
		drive    = '0;
		case (phase_q)
			PH_WAIT_RISE: begin
				if (now_high && !was_high) begin
					timer_d = '0;
					phase_d = PH_MEASURE;
				end
			end
			PH_MEASURE: begin
				timer_d = timer_inc;
				if (!now_high && was_high) begin
					hit     = 1'b1;
					phase_d = PH_GAP;
					count_d = '0;
				end
			end
			PH_GAP: begin
				count_d = count_inc;
				if (count_inc >= cfg_live.gap_lim) begin
					sensor_d = sensor_next;
					phase_d  = PH_TRIGGER;
					count_d  = '0;
				end
			end
			default: begin
				drive   = SENSOR_COUNT'(1) << sensor_q;
				count_d = count_inc;
				if (count_inc >= CNT_W'(cfg_live.trig_lim)) begin
					phase_d = PH_WAIT_RISE;
					count_d = '0;
				end
			end
		endcase
	end

	// Advance state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TRIGGER;
			sensor_q <= '0;
			count_q  <= '0;
			prev_q   <= '0;
			timer_q  <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			sensor_q <= sensor_d;
			count_q  <= count_d;
			prev_q   <= tick.echo_levels;
			timer_q  <= timer_d;
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	// Stage 1 payload; zero ticks when no echo ends so the distance is zero
	always_ff @(posedge clk) begin
		if (take) begin
			drive_s1  <= drive;
			hit_s1    <= hit;
			sensor_s1 <= sensor_q;
			ticks_s1  <= hit ? timer_inc : '0;
		end
	end

	assign meta_s1 = {drive_s1, hit_s1, sensor_s1};

endmodule

// ----- rtl/core/uer_scale.sv -----
module uer_scale import uer_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF,
	parameter int META_W     = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	output logic                  ready_s1,
	input  logic [META_W-1:0]     meta_s1,
	input  logic [TIMER_BITS-1:0] ticks_s1,
	input  logic [SPEED_W-1:0]    speed,
	output logic                  valid_s4,
	input  logic                  ready_s4,
	output logic [META_W-1:0]     meta_s4,
	output logic [DIST_W-1:0]     dist_s4
);

	localparam int PROD_W  = TIMER_BITS + SPEED_W;
	localparam int SHIFT_W = PROD_W - DIV_SHIFT;
	localparam int RPROD_W = RECIP_IN_W + 32;

	logic                 valid_s2, valid_s3;
	logic                 ready_s2, ready_s3;
	logic [META_W-1:0]    meta_s2, meta_s3;
	logic [PROD_W-1:0]    prod_s2;
	logic [SHIFT_W-1:0]   shifted;
	logic                 sat_s3;
	logic [RPROD_W-1:0]   recip_s3;

	// Each stage takes a new item when empty or when it moves on
	assign ready_s3 = !valid_s4 || ready_s4;
	assign ready_s2 = !valid_s3 || ready_s3;
	assign ready_s1 = !valid_s2 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s2 <= valid_s1;
			if (ready_s2) valid_s3 <= valid_s2;
			if (ready_s3) valid_s4 <= valid_s3;
		end
	end

	// Stage 2: ticks times speed term
	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			meta_s2 <= meta_s1;
			prod_s2 <= PROD_W'(ticks_s1) * PROD_W'(speed);
		end
	end

	// Stage 3: drop the factor 64, flag overflow, multiply by reciprocal of 25
	assign shifted = prod_s2[PROD_W-1:DIV_SHIFT];

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s2) begin
			meta_s3  <= meta_s2;
			sat_s3   <= 64'(shifted) >= SAT_LIMIT;
			recip_s3 <= RPROD_W'(RECIP_IN_W'(shifted)) * RPROD_W'(RECIP_MUL);
		end
	end

	// Stage 4: take the quotient or saturate
	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s3) begin
			meta_s4 <= meta_s3;
			dist_s4 <= sat_s3 ? DIST_MAX : recip_s3[RECIP_SHIFT +: DIST_W];
		end
	end

endmodule

// ----- rtl/core/ultrasonic_echo_ranger_unit.sv -----
// Channel   Dir   Payload                                           Transfer
// tick      in    echo_levels                                       valid & ready
// result    out   trigger_drive, result_valid, sensor_index,        valid & ready
//                 distance_um
// cfg       in    index, data (0 temperature, 1 trigger, 2 gap)     valid & ready
//
// One tick is taken every cycle while the stages are not all full; its result
// is offered after the sequencer register and the product,
// reciprocal and saturate stages of the distance path.
// arst_n returns the registers to their defaults and the sequencer to the
// trigger phase of sensor 0. A stalled result holds the last stage; the
// stages behind it keep filling, so ticks stop only once all are full.
module ultrasonic_echo_ranger_unit import uer_pkg::*; #(
	parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
	parameter int TIMER_BITS   = TIMER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	uer_tick_if.sink    tick,
	uer_result_if.source result,
	uer_cfg_if.sink     cfg
);

	localparam int IDX_W  = $clog2(SENSOR_COUNT);
	localparam int META_W = SENSOR_COUNT + 1 + IDX_W;

	uer_cfg_t              cfg_live;
	logic                  valid_s1, ready_s1;
	logic [META_W-1:0]     meta_s1, meta_s4;
	logic [TIMER_BITS-1:0] ticks_s1;
	logic [DIST_W-1:0]     dist_s4;

	uer_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_live (cfg_live)
	);

	uer_seq #(
		.SENSOR_COUNT (SENSOR_COUNT),
		.TIMER_BITS   (TIMER_BITS),
		.META_W       (META_W)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick),
		.cfg_live (cfg_live),
		.valid_s1 (valid_s1),
		.ready_s1 (ready_s1),
		.meta_s1  (meta_s1),
		.ticks_s1 (ticks_s1)
	);

	uer_scale #(
		.TIMER_BITS (TIMER_BITS),
		.META_W     (META_W)
	) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.ready_s1 (ready_s1),
		.meta_s1  (meta_s1),
		.ticks_s1 (ticks_s1),
		.speed    (cfg_live.speed),
		.valid_s4 (result.valid),
		.ready_s4 (result.ready),
		.meta_s4  (meta_s4),
		.dist_s4  (dist_s4)
	);

	// Unpack the result fields
	assign result.trigger_drive = meta_s4[META_W-1 -: SENSOR_COUNT];
	assign result.result_valid  = meta_s4[IDX_W];
	assign result.sensor_index  = meta_s4[IDX_W-1:0];
	assign result.distance_um   = dist_s4;

endmodule

// ----- tb/tb_ultrasonic_echo_ranger_unit.sv -----
module tb_ultrasonic_echo_ranger_unit;
	import uer_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CLK_HALF     = 10;
	localparam int          RESET_CYCLES = 12;
	localparam int          IDLE_PCT     = 20;
	localparam int          LONG_HOLD    = 120;
	localparam int          DRAIN_CYCLES = 8;
	localparam int          RANDOM_TICKS = 750;
	localparam int          MIN_SEGS     = 3;
	localparam int          SEGMENTS     = 6;
	localparam int          MAX_REPORTS  = 40;
	localparam longint      CYCLE_LIMIT  = 1_000_000;
	localparam logic [63:0] SOUND_DIV    = 64'd1600;
	localparam int          NSENS        = SENSOR_COUNT_DEF;

	typedef enum logic [1:0] {
		SEQ_TRIGGER,
		SEQ_WAIT_RISE,
		SEQ_MEASURE,
		SEQ_GAP
	} seq_phase_e;

	typedef struct packed {
		logic [1:0]                 sensor;
		seq_phase_e                 phase;
		logic [CNT_W-1:0]           count;
		logic [NSENS-1:0]           prev;
		logic [TIMER_BITS_DEF-1:0]  timer;
	} seq_state_t;

	typedef struct packed {
		logic [NSENS-1:0]  drive;
		logic              hit;
		logic [1:0]        idx;
		logic [DIST_W-1:0] dist_um;
	} tick_result_t;

	logic clk;
	logic arst_n;

	uer_tick_if   #(.SENSOR_COUNT(NSENS)) tick_bus ();
	uer_result_if #(.SENSOR_COUNT(NSENS)) result_bus ();
	uer_cfg_if                            cfg_bus ();

	ultrasonic_echo_ranger_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	// Register copies, sequencer state at the block and at the end of the feed
	logic [TEMP_W-1:0] temp_cfg = TEMP_RST;
	logic [TRIG_W-1:0] trig_cfg = TRIG_RST;
	logic [GAP_W-1:0]  gap_cfg  = GAP_RST;
	seq_state_t        model_st = '0;
	seq_state_t        plan_st  = '0;

	logic [NSENS-1:0] echo_feed[$];
	tick_result_t     due_results[$];

	logic   tick_done   = 1'b0;
	logic   steady      = 1'b0;
	int     hold_req    = 0;
	int     hold_ack    = 0;
	int     hold_left   = 0;
	longint cycle_count = 0;
	int     bad_count   = 0;
	int     res_seen    = 0;
	int     hits_seen   = 0;
	int     ticks_taken = 0;
	int     fed_total   = 0;
	int     writes_done = 0;

	// Distance in micrometres for an echo of the given tick count
	function automatic logic [DIST_W-1:0] echo_to_um(input logic [TIMER_BITS_DEF-1:0] ticks);
		int          speed;
		logic [63:0] um;
		speed = SPEED_BASE + SPEED_PER_DEG * int'($signed(temp_cfg));
		um = (64'(ticks) * 64'(speed)) / SOUND_DIV;
		if (um > 64'(DIST_MAX)) begin
			um = 64'(DIST_MAX);
		end
		return um[DIST_W-1:0];
	endfunction

	// Advance the sequencer by one tick and return what the block reports for it
	function automatic tick_result_t advance_sequencer(inout seq_state_t s,
			input logic [NSENS-1:0] lv);
		tick_result_t r;
		logic         now_hi;
		logic         was_hi;
		logic [CNT_W-1:0] lim;
		r = '0;
		r.idx = s.sensor;
		now_hi = lv[s.sensor];
		was_hi = s.prev[s.sensor];
		case (s.phase)
			SEQ_WAIT_RISE: begin
				if (now_hi && !was_hi) begin
					s.timer = '0;
					s.phase = SEQ_MEASURE;
				end
			end
			SEQ_MEASURE: begin
				if (s.timer != {TIMER_BITS_DEF{1'b1}}) begin
					s.timer = s.timer + 1'b1;
				end
				if (!now_hi && was_hi) begin
					r.hit = 1'b1;
					r.dist_um = echo_to_um(s.timer);
					s.phase = SEQ_GAP;
					s.count = '0;
				end
			end
			SEQ_GAP: begin
				lim = (gap_cfg == '0) ? CNT_W'(1) : CNT_W'(gap_cfg);
				s.count = s.count + 1'b1;
				if (s.count >= lim) begin
					s.sensor = s.sensor + 1'b1;
					s.phase = SEQ_TRIGGER;
					s.count = '0;
				end
			end
			default: begin
				r.drive = NSENS'(1) << s.sensor;
				lim = (trig_cfg == '0) ? CNT_W'(1) : CNT_W'(trig_cfg);
				s.count = s.count + 1'b1;
				if (s.count >= lim) begin
					s.phase = SEQ_WAIT_RISE;
					s.count = '0;
				end
			end
		endcase
		s.prev = lv;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		bad_count++;
		if (bad_count <= MAX_REPORTS) begin
			$display("mismatch on result %0d: %s got %0d want %0d", res_seen, what, got, want);
		end
	endtask

	// Queue one tick and track where the sequencer will be after it
	task automatic feed(input logic [NSENS-1:0] lv);
		echo_feed.push_back(lv);
		void'(advance_sequencer(plan_st, lv));
		fed_total++;
	endtask

	function automatic logic [NSENS-1:0] levels_with(input logic hi);
		logic [NSENS-1:0] lv;
		lv = NSENS'($urandom_range(2**NSENS - 1));
		lv[plan_st.sensor] = hi;
		return lv;
	endfunction

	// Run to the wait phase, then give the served sensor a clean echo pulse
	task automatic echo_cycle(input int hi_len, input int lead);
		while (plan_st.phase != SEQ_WAIT_RISE) begin
			feed(NSENS'($urandom_range(2**NSENS - 1)));
		end
		repeat (lead + 1) feed(levels_with(1'b0));
		repeat (hi_len) feed(levels_with(1'b1));
		feed(levels_with(1'b0));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			REG_TEMP: temp_cfg = val[TEMP_W-1:0];
			REG_TRIG: trig_cfg = val[TRIG_W-1:0];
			REG_GAP:  gap_cfg  = val[GAP_W-1:0];
			default: ;
		endcase
		writes_done++;
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic set_temp(input int celsius);
		write_reg(REG_TEMP, CFG_DATA_W'(8'(celsius)));
	endtask

	// Hold until every queued tick has gone in and every result has come out
	task automatic settle();
		do @(posedge clk);
		while (echo_feed.size() != 0 || tick_bus.valid || due_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		plan_st = model_st;
	endtask

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycle_count);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Tick driver: offer the next queued tick once the current one is taken
	always @(negedge clk) begin
		if (arst_n && (!tick_bus.valid || tick_done)) begin
			if (echo_feed.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
				tick_bus.echo_levels <= echo_feed.pop_front();
				tick_bus.valid <= 1'b1;
			end else begin
				tick_bus.valid <= 1'b0;
			end
		end
	end

	// Result sink: random back-pressure, plus one long hold when requested
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				result_bus.ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_ack != hold_req) begin
				hold_ack <= hold_req;
				hold_left <= LONG_HOLD;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Monitor: check result transfers, then predict for tick transfers
	always @(posedge clk) begin : monitor
		tick_result_t want;
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			tick_done <= tick_bus.valid && tick_bus.ready;
			if (result_bus.valid && result_bus.ready) begin
				res_seen++;
				if (due_results.size() == 0) begin
					flag_mismatch("result with nothing due, distance", result_bus.distance_um, 0);
				end else begin
					want = due_results.pop_front();
					if (want.hit) begin
						hits_seen++;
					end
					if (result_bus.trigger_drive !== want.drive) begin
						flag_mismatch("trigger_drive", result_bus.trigger_drive, want.drive);
					end
					if (result_bus.result_valid !== want.hit) begin
						flag_mismatch("result_valid", result_bus.result_valid, want.hit);
					end
					if (result_bus.sensor_index !== want.idx) begin
						flag_mismatch("sensor_index", result_bus.sensor_index, want.idx);
					end
					if (result_bus.distance_um !== want.dist_um) begin
						flag_mismatch("distance_um", result_bus.distance_um, want.dist_um);
					end
				end
			end
			if (tick_bus.valid && tick_bus.ready) begin
				due_results.push_back(advance_sequencer(model_st, tick_bus.echo_levels));
				ticks_taken++;
			end
		end
	end

	initial begin
		int seg;
		int pick;
		int rand_start;
		arst_n = 1'b0;
		tick_bus.valid = 1'b0;
		tick_bus.echo_levels = '0;
		result_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_TEMP;
		cfg_bus.data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset defaults: sensor 0 in its trigger pulse, echo extremes ignored
		repeat (12) feed(NSENS'($urandom_range(2**NSENS - 1)));
		feed('0);
		feed('1);
		settle();

		// Cold air, one-tick trigger and gap
		set_temp(-40);
		write_reg(REG_TRIG, CFG_DATA_W'(1));
		write_reg(REG_GAP, CFG_DATA_W'(1));
		echo_cycle(1, 0);
		// served line still high as the wait begins: needs a fresh rise
		while (plan_st.phase != SEQ_WAIT_RISE) begin
			feed(levels_with(1'b1));
		end
		feed(levels_with(1'b1));
		feed(levels_with(1'b1));
		feed(levels_with(1'b0));
		repeat (3) feed(levels_with(1'b1));
		feed(levels_with(1'b0));
		echo_cycle(4, 1);
		echo_cycle(2, 0);
		settle();

		// Hot air, zero trigger and gap count as one tick
		set_temp(85);
		write_reg(REG_TRIG, '0);
		write_reg(REG_GAP, '0);
		repeat (4) echo_cycle($urandom_range(1, 8), $urandom_range(0, 2));
		settle();

		// Random segments: mostly clean pulses, some long, some noise or cut short
		seg = 0;
		rand_start = fed_total;
		while (seg < MIN_SEGS || fed_total - rand_start < RANDOM_TICKS) begin
			if (seg % 2 == 0) begin
				set_temp(int'($urandom_range(125)) - 40);
				write_reg(REG_TRIG, CFG_DATA_W'($urandom_range(1, 6)));
				write_reg(REG_GAP, CFG_DATA_W'($urandom_range(1, 6)));
			end
			steady = (seg == 2);
			repeat (SEGMENTS) begin
				pick = $urandom_range(19);
				if (pick < 14) begin
					echo_cycle($urandom_range(1, 40), $urandom_range(0, 3));
				end else if (pick < 16) begin
					echo_cycle($urandom_range(100, 400), $urandom_range(0, 3));
				end else if (pick < 18) begin
					repeat ($urandom_range(1, 12)) feed(NSENS'($urandom_range(2**NSENS - 1)));
				end else begin
					while (plan_st.phase != SEQ_WAIT_RISE) begin
						feed(NSENS'($urandom_range(2**NSENS - 1)));
					end
					repeat ($urandom_range(1, 4)) feed(levels_with(1'b1));
					repeat ($urandom_range(0, 3)) feed(NSENS'($urandom_range(2**NSENS - 1)));
				end
			end
			// sink holds off while the driver keeps offering ticks
			if (seg == 1) begin
				hold_req++;
			end
			settle();
			steady = 1'b0;
			seg++;
		end

		// Park the served sensor in its wait phase while the limits are still short
		while (plan_st.phase != SEQ_WAIT_RISE) begin
			feed(NSENS'($urandom_range(2**NSENS - 1)));
		end
		settle();

		// Full-scale trigger and gap, temperature register with every bit set
		set_temp(-1);
		write_reg(REG_TRIG, CFG_DATA_W'({TRIG_W{1'b1}}));
		write_reg(REG_GAP, {CFG_DATA_W{1'b1}});
		repeat (2) feed(levels_with(1'b0));
		repeat (20) feed(levels_with(1'b1));
		feed(levels_with(1'b0));
		repeat (40) feed(NSENS'($urandom_range(2**NSENS - 1)));
		settle();

		$display("covered %0d echo ticks and %0d result transfers, %0d with a distance",
			ticks_taken, res_seen, hits_seen);
		$display("%0d register writes: -40..85 C, trigger and gap from zero to full scale",
			writes_done);
		if (bad_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", bad_count);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
